>>> sv/bqtdf2_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqtdf2_pkg: shared types and constants for the multichannel biquad
// Field widths, fixed-point scaling, register indexes and sequencer states.
// ----------------------------------------------------------------------------
package bqtdf2_pkg;

  localparam int NUM_CHANNELS = 8;
  localparam int CHAN_BITS    = 3;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEF_BITS    = 32;
  localparam int COEF_FRAC    = 28;
  localparam int STATE_BITS   = 48;

  // coefficient is consumed one digit at a time, LSB first; only the top digit is signed
  localparam int DIGIT_BITS = 4;
  localparam int NUM_DIGITS = COEF_BITS / DIGIT_BITS;
  localparam int CNT_BITS   = $clog2(NUM_DIGITS + 1);

  // running partial product and the full product word {acc, low}
  localparam int ACC_BITS  = STATE_BITS + DIGIT_BITS + 1;
  localparam int PROD_BITS = ACC_BITS + COEF_BITS;
  localparam int TERM_BITS = STATE_BITS + 8;

  // product scaling down to Q8.40
  localparam int XSHIFT = SAMPLE_BITS - 13;
  localparam int YSHIFT = COEF_FRAC;

  // output rounding: add half, then drop OUT_SHIFT bits
  localparam int OUT_SHIFT = 41 - SAMPLE_BITS;
  localparam int RND_BITS  = STATE_BITS + 1 - OUT_SHIFT;
  localparam logic [STATE_BITS:0] RND_HALF = (STATE_BITS + 1)'(1) << (OUT_SHIFT - 1);

  // configuration register indexes
  localparam int CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_B0 = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_B1 = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_B2 = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_A1 = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_A2 = 3'd4;

  localparam logic [COEF_BITS-1:0] COEF_B0_RESET = 32'h1000_0000;

  // input word actions
  localparam logic ACT_FILTER = 1'b0;
  localparam logic ACT_CLEAR  = 1'b1;

  // idle state plus one state per product of the section
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B0,
    ST_B1,
    ST_A1,
    ST_B2,
    ST_A2
  } state_t;

endpackage
`default_nettype wire

>>> sv/bqtdf2_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqtdf2_in_if: input channel of the biquad
// Carries one action, sample and channel per word with valid/ready.
// ----------------------------------------------------------------------------
interface bqtdf2_in_if;
  logic                                         valid;
  logic                                         ready;
  logic                                         action;
  logic signed [bqtdf2_pkg::SAMPLE_BITS-1:0]    sample_in;
  logic        [bqtdf2_pkg::CHAN_BITS-1:0]      chan;

  modport source (output valid, action, sample_in, chan, input ready);
  modport sink   (input valid, action, sample_in, chan, output ready);
endinterface
`default_nettype wire

>>> sv/bqtdf2_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqtdf2_out_if: result channel of the biquad
// Carries the filtered sample, its channel and the clip flag with valid/ready.
// ----------------------------------------------------------------------------
interface bqtdf2_out_if;
  logic                                         valid;
  logic                                         ready;
  logic signed [bqtdf2_pkg::SAMPLE_BITS-1:0]    sample_out;
  logic        [bqtdf2_pkg::CHAN_BITS-1:0]      out_chan;
  logic                                         clipped;

  modport source (output valid, sample_out, out_chan, clipped, input ready);
  modport sink   (input valid, sample_out, out_chan, clipped, output ready);
endinterface
`default_nettype wire

>>> sv/bqtdf2_cfg_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bqtdf2_cfg_if: coefficient write channel of the biquad
// Carries a register index and write data with valid/ready.
// ----------------------------------------------------------------------------
interface bqtdf2_cfg_if;
  logic                                         valid;
  logic                                         ready;
  logic [bqtdf2_pkg::CFG_IDX_BITS-1:0]          index;
  logic [bqtdf2_pkg::COEF_BITS-1:0]             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/biquad_tdf2_multichannel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// biquad_tdf2_multichannel: transposed direct form II biquad, 8 channels
// One shared digit-serial multiplier, per-channel delay words, saturated out.
// ----------------------------------------------------------------------------
// A filter word occupies the block from acceptance until the five coefficient
// products (b0, b1, a1, b2, a2) have gone one after another through a single
// multiplier, which consumes the 32-bit coefficient 4 bits per cycle and then
// folds each product into the sums; only then is the next word taken. A clear
// word gives no result. The result sits in an output register, so a new word is
// accepted while the previous result waits; the last product holds until that
// register is free. Coefficients reset to pass-through and are written through
// the cfg port (always ready); the user must write them only while no word is in
// flight, and the block itself has no check for this.
// ----------------------------------------------------------------------------
module biquad_tdf2_multichannel (
  input  wire              clk,
  input  wire              rst_n,
  bqtdf2_in_if.sink        in_bus,
  bqtdf2_out_if.source     out_bus,
  bqtdf2_cfg_if.sink       cfg_bus
);

  // coefficients
  logic [bqtdf2_pkg::COEF_BITS-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;

  // per-channel delay words; vld_r marks words written since the last clear
  logic signed [bqtdf2_pkg::STATE_BITS-1:0] d1_r [bqtdf2_pkg::NUM_CHANNELS];
  logic signed [bqtdf2_pkg::STATE_BITS-1:0] d2_r [bqtdf2_pkg::NUM_CHANNELS];
  logic [bqtdf2_pkg::NUM_CHANNELS-1:0]      vld_r;

  bqtdf2_pkg::state_t state_r, state_nxt;

  // word in flight
  logic signed [bqtdf2_pkg::SAMPLE_BITS-1:0] x_r;
  logic [bqtdf2_pkg::CHAN_BITS-1:0]          ch_r;
  logic signed [bqtdf2_pkg::STATE_BITS-1:0]  z1_r, z2_r, y_r;
  logic signed [bqtdf2_pkg::TERM_BITS-1:0]   s1_r, s2_r;

  // digit-serial multiplier
  logic signed [bqtdf2_pkg::STATE_BITS-1:0] op_r;
  logic [bqtdf2_pkg::COEF_BITS-1:0]         cshift_r;
  logic signed [bqtdf2_pkg::ACC_BITS-1:0]   acc_r;
  logic [bqtdf2_pkg::COEF_BITS-1:0]         low_r;
  logic [bqtdf2_pkg::CNT_BITS-1:0]          cnt_r;

  logic signed [bqtdf2_pkg::DIGIT_BITS:0]   digit_s;
  logic signed [bqtdf2_pkg::ACC_BITS-1:0]   part;
  logic signed [bqtdf2_pkg::ACC_BITS-1:0]   acc_sum;
  logic [bqtdf2_pkg::PROD_BITS-1:0]         prod;
  logic signed [bqtdf2_pkg::TERM_BITS-1:0]  term_x, term_y;
  logic                                     cnt_done;

  // output register
  logic                                     out_valid_r;
  logic signed [bqtdf2_pkg::SAMPLE_BITS-1:0] out_sample_r;
  logic [bqtdf2_pkg::CHAN_BITS-1:0]         out_chan_r;
  logic                                     out_clip_r;
  logic                                     out_free;

  // rounding of y
  logic [bqtdf2_pkg::STATE_BITS:0]          rnd;
  logic [bqtdf2_pkg::RND_BITS-1:0]          rnd_q;
  logic signed [bqtdf2_pkg::SAMPLE_BITS-1:0] y_out;
  logic                                     y_clip;

  // control
  logic chan_ok, in_rdy, start, clr, step, ph_end, finish;

  function automatic logic [bqtdf2_pkg::STATE_BITS-1:0] sat_state(
    input logic [bqtdf2_pkg::TERM_BITS-1:0] v
  );
    logic [bqtdf2_pkg::TERM_BITS-bqtdf2_pkg::STATE_BITS:0] hi;
    hi = v[bqtdf2_pkg::TERM_BITS-1:bqtdf2_pkg::STATE_BITS-1];
    if ((&hi) || (~|hi)) begin
      return v[bqtdf2_pkg::STATE_BITS-1:0];
    end else if (v[bqtdf2_pkg::TERM_BITS-1]) begin
      return {1'b1, {(bqtdf2_pkg::STATE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(bqtdf2_pkg::STATE_BITS-1){1'b1}}};
    end
  endfunction

  assign chan_ok  = (int'(in_bus.chan) < bqtdf2_pkg::NUM_CHANNELS);
  assign cnt_done = (cnt_r == bqtdf2_pkg::CNT_BITS'(bqtdf2_pkg::NUM_DIGITS));
  assign out_free = !out_valid_r || out_bus.ready;

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bqtdf2_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_rdy    = 1'b0;
    start     = 1'b0;
    clr       = 1'b0;
    step      = 1'b0;
    ph_end    = 1'b0;
    finish    = 1'b0;
    case (state_r)
      bqtdf2_pkg::ST_IDLE: begin
        in_rdy = 1'b1;
        if (in_bus.valid) begin
          if (in_bus.action == bqtdf2_pkg::ACT_CLEAR) begin
            clr = 1'b1;
          end else if (chan_ok) begin
            start     = 1'b1;
            state_nxt = bqtdf2_pkg::ST_B0;
          end
        end
      end
      bqtdf2_pkg::ST_B0: begin
        step   = !cnt_done;
        ph_end = cnt_done;
        if (cnt_done) state_nxt = bqtdf2_pkg::ST_B1;
      end
      bqtdf2_pkg::ST_B1: begin
        step   = !cnt_done;
        ph_end = cnt_done;
        if (cnt_done) state_nxt = bqtdf2_pkg::ST_A1;
      end
      bqtdf2_pkg::ST_A1: begin
        step   = !cnt_done;
        ph_end = cnt_done;
        if (cnt_done) state_nxt = bqtdf2_pkg::ST_B2;
      end
      bqtdf2_pkg::ST_B2: begin
        step   = !cnt_done;
        ph_end = cnt_done;
        if (cnt_done) state_nxt = bqtdf2_pkg::ST_A2;
      end
      bqtdf2_pkg::ST_A2: begin
        step = !cnt_done;
        // hold the last product until the output register is free
        if (cnt_done && out_free) begin
          finish    = 1'b1;
          state_nxt = bqtdf2_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = bqtdf2_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_bus.ready = in_rdy;

  // ---------------------------------------------------------------- config
  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r <= bqtdf2_pkg::COEF_B0_RESET;
      b1_r <= '0;
      b2_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
    end else if (cfg_bus.valid) begin
      case (cfg_bus.index)
        bqtdf2_pkg::REG_B0: b0_r <= cfg_bus.data;
        bqtdf2_pkg::REG_B1: b1_r <= cfg_bus.data;
        bqtdf2_pkg::REG_B2: b2_r <= cfg_bus.data;
        bqtdf2_pkg::REG_A1: a1_r <= cfg_bus.data;
        bqtdf2_pkg::REG_A2: a2_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- multiplier
  // top digit of the coefficient carries the sign
  assign digit_s = (cnt_r == bqtdf2_pkg::CNT_BITS'(bqtdf2_pkg::NUM_DIGITS - 1)) ?
                   {cshift_r[bqtdf2_pkg::DIGIT_BITS-1], cshift_r[bqtdf2_pkg::DIGIT_BITS-1:0]} :
                   {1'b0, cshift_r[bqtdf2_pkg::DIGIT_BITS-1:0]};
  assign part    = bqtdf2_pkg::ACC_BITS'(op_r) * bqtdf2_pkg::ACC_BITS'(digit_s);
  assign acc_sum = acc_r + part;

  // full product, low bits collected as they shift out of the accumulator
  assign prod   = {acc_r, low_r};
  assign term_x = $signed(prod[bqtdf2_pkg::XSHIFT +: bqtdf2_pkg::TERM_BITS]);
  assign term_y = $signed(prod[bqtdf2_pkg::YSHIFT +: bqtdf2_pkg::TERM_BITS]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start || ph_end) begin
      cnt_r <= '0;
    end else if (step) begin
      cnt_r <= cnt_r + bqtdf2_pkg::CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r      <= in_bus.sample_in;
      ch_r     <= in_bus.chan;
      z1_r     <= vld_r[in_bus.chan] ? d1_r[in_bus.chan] : '0;
      z2_r     <= vld_r[in_bus.chan] ? d2_r[in_bus.chan] : '0;
      op_r     <= bqtdf2_pkg::STATE_BITS'(in_bus.sample_in);
      cshift_r <= b0_r;
      acc_r    <= '0;
    end else if (step) begin
      acc_r    <= acc_sum >>> bqtdf2_pkg::DIGIT_BITS;
      low_r    <= {acc_sum[bqtdf2_pkg::DIGIT_BITS-1:0],
                   low_r[bqtdf2_pkg::COEF_BITS-1:bqtdf2_pkg::DIGIT_BITS]};
      cshift_r <= cshift_r >> bqtdf2_pkg::DIGIT_BITS;
    end else if (ph_end) begin
      acc_r <= '0;
      case (state_r)
        bqtdf2_pkg::ST_B0: begin
          y_r      <= sat_state(term_x + bqtdf2_pkg::TERM_BITS'(z1_r));
          op_r     <= bqtdf2_pkg::STATE_BITS'(x_r);
          cshift_r <= b1_r;
        end
        bqtdf2_pkg::ST_B1: begin
          s1_r     <= term_x + bqtdf2_pkg::TERM_BITS'(z2_r);
          op_r     <= y_r;
          cshift_r <= a1_r;
        end
        bqtdf2_pkg::ST_A1: begin
          s1_r     <= s1_r - term_y;
          op_r     <= bqtdf2_pkg::STATE_BITS'(x_r);
          cshift_r <= b2_r;
        end
        bqtdf2_pkg::ST_B2: begin
          s2_r     <= term_x;
          op_r     <= y_r;
          cshift_r <= a2_r;
        end
        default: ;
      endcase
    end
    if (finish) begin
      d1_r[ch_r] <= sat_state(s1_r);
      d2_r[ch_r] <= sat_state(s2_r - term_y);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clr) begin
      vld_r <= '0;
    end else if (finish) begin
      vld_r[ch_r] <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- output
  // round half up, drop fraction bits, clamp to the sample range
  always_comb begin
    rnd   = {y_r[bqtdf2_pkg::STATE_BITS-1], y_r} + bqtdf2_pkg::RND_HALF;
    rnd_q = rnd[bqtdf2_pkg::STATE_BITS:bqtdf2_pkg::OUT_SHIFT];
    if ((&rnd_q[bqtdf2_pkg::RND_BITS-1:bqtdf2_pkg::SAMPLE_BITS-1]) ||
        (~|rnd_q[bqtdf2_pkg::RND_BITS-1:bqtdf2_pkg::SAMPLE_BITS-1])) begin
      y_out  = rnd_q[bqtdf2_pkg::SAMPLE_BITS-1:0];
      y_clip = 1'b0;
    end else if (rnd_q[bqtdf2_pkg::RND_BITS-1]) begin
      y_out  = {1'b1, {(bqtdf2_pkg::SAMPLE_BITS-1){1'b0}}};
      y_clip = 1'b1;
    end else begin
      y_out  = {1'b0, {(bqtdf2_pkg::SAMPLE_BITS-1){1'b1}}};
      y_clip = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_sample_r <= y_out;
      out_chan_r   <= ch_r;
      out_clip_r   <= y_clip;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.sample_out = out_sample_r;
  assign out_bus.out_chan   = out_chan_r;
  assign out_bus.clipped    = out_clip_r;

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the multichannel TDF-II biquad
// Drives sample and clear words with random gaps, reprograms the five
// coefficients between phases, and checks every filtered word against a
// bit-exact fixed-point model of the section kept per channel.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DRAIN_CYCLES = 64;

  localparam logic [bqtdf2_pkg::COEF_BITS-1:0]   COEF_MAX   = 32'h7FFF_FFFF;
  localparam logic [bqtdf2_pkg::COEF_BITS-1:0]   COEF_MIN   = 32'h8000_0000;
  localparam logic [bqtdf2_pkg::SAMPLE_BITS-1:0] SAMPLE_MAX = 24'h7F_FFFF;
  localparam logic [bqtdf2_pkg::SAMPLE_BITS-1:0] SAMPLE_MIN = 24'h80_0000;

  typedef logic signed [2*bqtdf2_pkg::STATE_BITS-1:0] wide_t;

  localparam wide_t STATE_HI = (wide_t'(1) <<< (bqtdf2_pkg::STATE_BITS - 1)) - wide_t'(1);
  localparam wide_t STATE_LO = -STATE_HI - wide_t'(1);
  localparam wide_t OUT_HI   = (wide_t'(1) <<< (bqtdf2_pkg::SAMPLE_BITS - 1)) - wide_t'(1);
  localparam wide_t OUT_LO   = -OUT_HI - wide_t'(1);
  localparam wide_t OUT_HALF = wide_t'(1) <<< (bqtdf2_pkg::OUT_SHIFT - 1);

  typedef enum logic [1:0] {
    STYLE_TAME,
    STYLE_WIDE,
    STYLE_WILD
  } coef_style_t;

  typedef struct packed {
    logic signed [bqtdf2_pkg::SAMPLE_BITS-1:0] sample_out;
    logic [bqtdf2_pkg::CHAN_BITS-1:0]          chan;
    logic                                      clipped;
  } filter_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bqtdf2_in_if  in_bus ();
  bqtdf2_out_if out_bus ();
  bqtdf2_cfg_if cfg_bus ();

  biquad_tdf2_multichannel dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model of the section: coefficients by register index, delay words by channel
  logic signed [bqtdf2_pkg::COEF_BITS-1:0]  coef_bank [0:4];
  logic signed [bqtdf2_pkg::STATE_BITS-1:0] tap_one [bqtdf2_pkg::NUM_CHANNELS];
  logic signed [bqtdf2_pkg::STATE_BITS-1:0] tap_two [bqtdf2_pkg::NUM_CHANNELS];
  filter_result_t                           pending_out [$];

  int send_gap_max = 18;
  int recv_gap_max = 18;
  int sink_hold    = 0;
  int err_count    = 0;
  int words_in     = 0;
  int clears_sent  = 0;
  int results_seen = 0;
  int clip_seen    = 0;
  int coef_sets    = 0;

  function automatic logic signed [bqtdf2_pkg::STATE_BITS-1:0] clamp_state(input wide_t v);
    if (v > STATE_HI) return STATE_HI[bqtdf2_pkg::STATE_BITS-1:0];
    if (v < STATE_LO) return STATE_LO[bqtdf2_pkg::STATE_BITS-1:0];
    return v[bqtdf2_pkg::STATE_BITS-1:0];
  endfunction

  // coef * sample, floored down to Q8.40
  function automatic wide_t scale_x(input logic signed [bqtdf2_pkg::COEF_BITS-1:0] c,
                                    input logic signed [bqtdf2_pkg::SAMPLE_BITS-1:0] x);
    wide_t prod;
    prod = c * x;
    return prod >>> bqtdf2_pkg::XSHIFT;
  endfunction

  // coef * state word, floored down to Q8.40
  function automatic wide_t scale_y(input logic signed [bqtdf2_pkg::COEF_BITS-1:0] c,
                                    input logic signed [bqtdf2_pkg::STATE_BITS-1:0] y);
    wide_t prod;
    prod = c * y;
    return prod >>> bqtdf2_pkg::YSHIFT;
  endfunction

  function automatic filter_result_t filter_sample(
    input logic [bqtdf2_pkg::CHAN_BITS-1:0]          ch,
    input logic signed [bqtdf2_pkg::SAMPLE_BITS-1:0] x
  );
    logic signed [bqtdf2_pkg::STATE_BITS-1:0] y;
    wide_t                                    r;
    filter_result_t                           res;
    y = clamp_state(scale_x(coef_bank[bqtdf2_pkg::REG_B0], x) + tap_one[ch]);
    tap_one[ch] = clamp_state(scale_x(coef_bank[bqtdf2_pkg::REG_B1], x)
                              - scale_y(coef_bank[bqtdf2_pkg::REG_A1], y) + tap_two[ch]);
    tap_two[ch] = clamp_state(scale_x(coef_bank[bqtdf2_pkg::REG_B2], x)
                              - scale_y(coef_bank[bqtdf2_pkg::REG_A2], y));
    r = y;
    r = (r + OUT_HALF) >>> bqtdf2_pkg::OUT_SHIFT;
    res.clipped = 1'b0;
    if (r > OUT_HI) begin
      r = OUT_HI;
      res.clipped = 1'b1;
    end else if (r < OUT_LO) begin
      r = OUT_LO;
      res.clipped = 1'b1;
    end
    res.sample_out = r[bqtdf2_pkg::SAMPLE_BITS-1:0];
    res.chan       = ch;
    return res;
  endfunction

  function automatic logic [bqtdf2_pkg::COEF_BITS-1:0] pick_coef(input coef_style_t style);
    case (style)
      STYLE_TAME:
        return bqtdf2_pkg::COEF_BITS'($urandom_range(0, 32'h1000_0000) - 32'h0800_0000);
      STYLE_WIDE:
        return bqtdf2_pkg::COEF_BITS'($urandom_range(0, 32'h4000_0000) - 32'h2000_0000);
      default: begin
        case ($urandom_range(0, 3))
          0:       return COEF_MAX;
          1:       return COEF_MIN;
          2:       return '0;
          default: return bqtdf2_pkg::COEF_BITS'($urandom);
        endcase
      end
    endcase
  endfunction

  function automatic logic [bqtdf2_pkg::SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return bqtdf2_pkg::SAMPLE_BITS'($urandom_range(0, 512) - 256);
      default: return bqtdf2_pkg::SAMPLE_BITS'($urandom);
    endcase
  endfunction

  // leave valid high on return; a gap before the next word or drain_results lowers it
  task automatic send_word(input logic act,
                           input logic [bqtdf2_pkg::SAMPLE_BITS-1:0] smp,
                           input logic [bqtdf2_pkg::CHAN_BITS-1:0] ch);
    int gap;
    gap = $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.action    <= act;
    in_bus.sample_in <= smp;
    in_bus.chan      <= ch;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    words_in++;
    if (act == bqtdf2_pkg::ACT_CLEAR) begin
      clears_sent++;
      for (int i = 0; i < bqtdf2_pkg::NUM_CHANNELS; i++) begin
        tap_one[i] = '0;
        tap_two[i] = '0;
      end
    end else begin
      // chan is 3 bits and all 8 channels exist, so every sample word yields a result
      pending_out.push_back(filter_sample(ch, $signed(smp)));
    end
  endtask

  task automatic send_random_word();
    if ($urandom_range(0, 29) == 0)
      send_word(bqtdf2_pkg::ACT_CLEAR, pick_sample(), bqtdf2_pkg::CHAN_BITS'($urandom));
    else
      send_word(bqtdf2_pkg::ACT_FILTER, pick_sample(),
                bqtdf2_pkg::CHAN_BITS'($urandom_range(0, bqtdf2_pkg::NUM_CHANNELS - 1)));
  endtask

  // drop valid, wait for every expected word, then let the datapath go quiet
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_coef(input logic [bqtdf2_pkg::CFG_IDX_BITS-1:0] idx,
                            input logic [bqtdf2_pkg::COEF_BITS-1:0] value);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx <= bqtdf2_pkg::REG_A2) coef_bank[idx] = value;
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_coefs(input logic [bqtdf2_pkg::COEF_BITS-1:0] b0, b1, b2, a1, a2);
    write_coef(bqtdf2_pkg::REG_B0, b0);
    write_coef(bqtdf2_pkg::REG_B1, b1);
    write_coef(bqtdf2_pkg::REG_B2, b2);
    write_coef(bqtdf2_pkg::REG_A1, a1);
    write_coef(bqtdf2_pkg::REG_A2, a2);
    coef_sets++;
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    err_count++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
  endtask

  // reset coefficients give pass-through, so each sample must come back unchanged
  task automatic test_reset_passthrough();
    logic [bqtdf2_pkg::SAMPLE_BITS-1:0] probe [bqtdf2_pkg::NUM_CHANNELS] = '{
      '0, SAMPLE_MAX, SAMPLE_MIN, 24'hFF_FFFF, 24'h00_0001, 24'h55_5555, 24'hAA_AAAA,
      24'h00_0100};
    for (int i = 0; i < bqtdf2_pkg::NUM_CHANNELS; i++)
      send_word(bqtdf2_pkg::ACT_FILTER, probe[i], bqtdf2_pkg::CHAN_BITS'(i));
    send_word(bqtdf2_pkg::ACT_CLEAR, SAMPLE_MAX,
              bqtdf2_pkg::CHAN_BITS'(bqtdf2_pkg::NUM_CHANNELS - 1));
    drain_results();
  endtask

  // full-scale coefficients and samples: output clipping and delay-word saturation
  task automatic test_saturation_extremes();
    program_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    for (int idx = bqtdf2_pkg::REG_A2 + 1; idx < (1 << bqtdf2_pkg::CFG_IDX_BITS); idx++)
      write_coef(bqtdf2_pkg::CFG_IDX_BITS'(idx), bqtdf2_pkg::COEF_BITS'($urandom));
    repeat (3) send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MAX, '0);
    repeat (2) send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MIN, '0);
    send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MAX,
              bqtdf2_pkg::CHAN_BITS'(bqtdf2_pkg::NUM_CHANNELS - 1));
    send_word(bqtdf2_pkg::ACT_CLEAR, '0, '0);
    send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MIN,
              bqtdf2_pkg::CHAN_BITS'(bqtdf2_pkg::NUM_CHANNELS - 1));
    send_word(bqtdf2_pkg::ACT_FILTER, '0, '0);
    drain_results();
    program_coefs(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MAX, bqtdf2_pkg::CHAN_BITS'(3));
    send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MIN, bqtdf2_pkg::CHAN_BITS'(3));
    send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MAX, bqtdf2_pkg::CHAN_BITS'(3));
    send_word(bqtdf2_pkg::ACT_FILTER, 24'h00_0001, bqtdf2_pkg::CHAN_BITS'(3));
    drain_results();
    program_coefs('0, '0, '0, '0, '0);
    send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MAX, bqtdf2_pkg::CHAN_BITS'(3));
    send_word(bqtdf2_pkg::ACT_FILTER, SAMPLE_MIN, bqtdf2_pkg::CHAN_BITS'(5));
    drain_results();
  endtask

  task automatic test_random_filters();
    coef_style_t style;
    for (int k = 0; k < 6; k++) begin
      style = coef_style_t'(k % 3);
      send_gap_max = (k % 3 == 1) ? 0 : 18;
      recv_gap_max = (k % 2 == 1) ? 0 : 18;
      program_coefs(pick_coef(style), pick_coef(style), pick_coef(style),
                    pick_coef(style), pick_coef(style));
      repeat (85) send_random_word();
      drain_results();
    end
  endtask

  // hold the sink off long enough for the block to fill and stall its input
  task automatic test_input_backpressure();
    send_gap_max = 0;
    recv_gap_max = 4;
    program_coefs(pick_coef(STYLE_TAME), pick_coef(STYLE_TAME), pick_coef(STYLE_TAME),
                  pick_coef(STYLE_TAME), pick_coef(STYLE_TAME));
    sink_hold = 400;
    repeat (40) send_random_word();
    drain_results();
  endtask

  initial begin : result_sink
    int             wait_cycles;
    filter_result_t want;
    out_bus.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      wait_cycles = sink_hold + $urandom_range(0, recv_gap_max);
      sink_hold   = 0;
      if (wait_cycles > 0) begin
        out_bus.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      results_seen++;
      if (out_bus.clipped) clip_seen++;
      if (pending_out.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result word, expected none, actual sample %0d chan %0d",
                 $time, out_bus.sample_out, out_bus.out_chan);
      end else begin
        want = pending_out.pop_front();
        if (out_bus.sample_out !== want.sample_out)
          report_field("sample_out", $signed(want.sample_out), $signed(out_bus.sample_out));
        if (out_bus.out_chan !== want.chan)
          report_field("out_chan", want.chan, out_bus.out_chan);
        if (out_bus.clipped !== want.clipped)
          report_field("clipped", want.clipped, out_bus.clipped);
      end
    end
  end

  initial begin : watchdog
    #20_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, pending_out.size());
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.action    <= bqtdf2_pkg::ACT_FILTER;
    in_bus.sample_in <= '0;
    in_bus.chan      <= '0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= bqtdf2_pkg::REG_B0;
    cfg_bus.data     <= '0;
    coef_bank[bqtdf2_pkg::REG_B0] = bqtdf2_pkg::COEF_B0_RESET;
    coef_bank[bqtdf2_pkg::REG_B1] = '0;
    coef_bank[bqtdf2_pkg::REG_B2] = '0;
    coef_bank[bqtdf2_pkg::REG_A1] = '0;
    coef_bank[bqtdf2_pkg::REG_A2] = '0;
    for (int i = 0; i < bqtdf2_pkg::NUM_CHANNELS; i++) begin
      tap_one[i] = '0;
      tap_two[i] = '0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_saturation_extremes();
    test_random_filters();
    test_input_backpressure();

    $display("Sent %0d words (%0d clears) across %0d coefficient settings plus reset.",
             words_in, clears_sent, coef_sets);
    $display("Checked %0d filtered words, %0d clipped, including a long output stall.",
             results_seen, clip_seen);
    if (err_count == 0 && pending_out.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
